// ----- hdl/fts_pkg.sv -----
// ============================================================================
// fts_pkg
// Shared widths, register indexes and reset values for the flat triangle
// shading pipeline.
// ============================================================================
`default_nettype none

package fts_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int LEVEL_W    = 8;

    // Internal arithmetic widths
    localparam int EDGE_W     = 17;   // vertex differences
    localparam int SUM_W      = 18;   // vertex sum, three times light
    localparam int DIR_W      = 19;   // light direction, scaled by three
    localparam int PROD_W     = 34;   // edge products
    localparam int NRM_W      = 35;   // normal components
    localparam int ND_W       = 54;   // normal times direction terms
    localparam int DOT_W      = 56;   // dot product sum
    localparam int DOTMAG_W   = 54;   // magnitude of a positive dot product
    localparam int NN_W       = 68;   // squared normal length
    localparam int DD_W       = 38;   // squared direction length
    localparam int HALF_NN_W  = 34;   // split of the normal length square
    localparam int BP_W       = 72;   // base partial products
    localparam int GD_W       = 62;   // gain times dot
    localparam int GD_LO_W    = 31;   // split of gain times dot
    localparam int BASE_W     = 106;  // squared lengths product
    localparam int RES_W      = 124;  // right-hand side and residual
    localparam int KB_W       = 116;  // running level times base
    localparam int SUMLVL_W   = 9;    // ambient plus level before clamp

    // Pipeline geometry
    localparam int SEARCH_STEPS = 8;
    localparam int PIPE_DEPTH   = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE   = 3'd4;

    localparam logic signed [COORD_W-1:0] LIGHT_RST   = 16'sd5120;
    localparam logic [LEVEL_W-1:0]        AMBIENT_RST = 8'd30;
    localparam logic [LEVEL_W-1:0]        DIFFUSE_RST = 8'd200;
    localparam logic [LEVEL_W-1:0]        LEVEL_MAX   = 8'd255;

endpackage

`default_nettype wire

// ----- hdl/flat_triangle_shading.sv -----
// ============================================================================
// flat_triangle_shading
// Flat Lambert shading of one view-space triangle per transfer: gray level
// from ambient plus gain times the clamped cosine to a point light.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready carries the nine vertex coordinates
//   (signed Q8.8). Output channel out_valid/out_ready carries gray_level and
//   lit_face. Configuration is a plain write port (cfg_we, cfg_idx,
//   cfg_wdata): light x, y, z, ambient level, diffuse gain at indexes 0..4;
//   other indexes are ignored. Write it only while the pipeline is empty.
//   A transfer loads the first of 17 register stages; the result is held in
//   the last. Throughput is one triangle per cycle while the output is not
//   stalled: 8 arithmetic stages form normal, direction, dot product and
//   squared lengths, then 8 stages resolve one bit each of the diffuse
//   level by shift-and-subtract, and one output register.
//   When the receiver stalls the whole pipeline holds; in_ready is low only
//   while the output register is full and out_ready is low.
//   Reset empties the pipeline and loads light (20,20,20), ambient 30 and
//   gain 200.
// ============================================================================
`default_nettype none

module flat_triangle_shading
    import fts_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_W-1:0]    ax,
    input  wire logic signed [COORD_W-1:0]    ay,
    input  wire logic signed [COORD_W-1:0]    az,
    input  wire logic signed [COORD_W-1:0]    bx,
    input  wire logic signed [COORD_W-1:0]    by_coord,
    input  wire logic signed [COORD_W-1:0]    bz,
    input  wire logic signed [COORD_W-1:0]    cx,
    input  wire logic signed [COORD_W-1:0]    cy,
    input  wire logic signed [COORD_W-1:0]    cz,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [LEVEL_W-1:0]                gray_level,
    output logic                              lit_face
);

    // Configuration registers
    logic signed [COORD_W-1:0] light_reg [3];
    logic [LEVEL_W-1:0]        ambient_reg;
    logic [LEVEL_W-1:0]        diffuse_reg;

    // Pipeline control
    logic                      adv;
    logic [PIPE_DEPTH-1:0]     vld_reg;

    // Stage registers
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   l3_reg [3];
    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [DIR_W-1:0]   dir2_reg [3];
    logic signed [NRM_W-1:0]   nrm_reg [3];
    logic signed [DIR_W-1:0]   dir3_reg [3];
    logic signed [ND_W-1:0]    nd_reg [3];
    logic [NN_W-1:0]           nn_reg [3];
    logic [DD_W-1:0]           dd_reg [3];
    logic signed [DOT_W-1:0]   dot_reg;
    logic [NN_W-1:0]           n2_reg;
    logic [DD_W-1:0]           d2_reg;
    logic                      lit_now;
    logic [GD_W-1:0]           gd_reg;
    logic [BP_W-1:0]           bl_reg;
    logic [BP_W-1:0]           bh_reg;
    logic [BASE_W-1:0]         base7_reg;
    logic [2*GD_LO_W-1:0]      ll_reg;
    logic [2*GD_LO_W-1:0]      lh_reg;
    logic [2*GD_LO_W-1:0]      hh_reg;
    logic [16:6]               lit_pipe_reg;

    // Search stage registers, index 0 feeds the first step
    logic [RES_W-1:0]          srch_r_reg    [SEARCH_STEPS+1];
    logic [KB_W-1:0]           srch_kb_reg   [SEARCH_STEPS+1];
    logic [LEVEL_W-1:0]        srch_k_reg    [SEARCH_STEPS+1];
    logic [BASE_W-1:0]         srch_base_reg [SEARCH_STEPS+1];

    // Output register
    logic [LEVEL_W-1:0]        gray_reg;
    logic                      lit_reg;
    logic [SUMLVL_W-1:0]       lvl_sum;
    logic [LEVEL_W-1:0]        k_use;

    // Write configuration; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg[0] <= LIGHT_RST;
            light_reg[1] <= LIGHT_RST;
            light_reg[2] <= LIGHT_RST;
            ambient_reg  <= AMBIENT_RST;
            diffuse_reg  <= DIFFUSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_LIGHT_X: light_reg[0] <= cfg_wdata;
                REG_LIGHT_Y: light_reg[1] <= cfg_wdata;
                REG_LIGHT_Z: light_reg[2] <= cfg_wdata;
                REG_AMBIENT: ambient_reg  <= cfg_wdata[LEVEL_W-1:0];
                REG_DIFFUSE: diffuse_reg  <= cfg_wdata[LEVEL_W-1:0];
                default:     ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output is held
    assign adv      = ~vld_reg[PIPE_DEPTH-1] | out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Stage 1: edges, vertex sum, three times light
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg[0]  <= EDGE_W'(bx) - EDGE_W'(ax);
            e1_reg[1]  <= EDGE_W'(by_coord) - EDGE_W'(ay);
            e1_reg[2]  <= EDGE_W'(bz) - EDGE_W'(az);
            e2_reg[0]  <= EDGE_W'(cx) - EDGE_W'(ax);
            e2_reg[1]  <= EDGE_W'(cy) - EDGE_W'(ay);
            e2_reg[2]  <= EDGE_W'(cz) - EDGE_W'(az);
            sum_reg[0] <= SUM_W'(ax) + SUM_W'(bx) + SUM_W'(cx);
            sum_reg[1] <= SUM_W'(ay) + SUM_W'(by_coord) + SUM_W'(cy);
            sum_reg[2] <= SUM_W'(az) + SUM_W'(bz) + SUM_W'(cz);
            for (int i = 0; i < 3; i++)
            begin
                l3_reg[i] <= SUM_W'(light_reg[i]) + SUM_W'(light_reg[i])
                           + SUM_W'(light_reg[i]);
            end
        end
    end

    // Stage 2: cross product terms, light direction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            prod_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            prod_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            prod_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            prod_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            prod_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                dir2_reg[i] <= DIR_W'(l3_reg[i]) - DIR_W'(sum_reg[i]);
            end
        end
    end

    // Stage 3: face normal
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nrm_reg[0] <= NRM_W'(prod_reg[0]) - NRM_W'(prod_reg[1]);
            nrm_reg[1] <= NRM_W'(prod_reg[2]) - NRM_W'(prod_reg[3]);
            nrm_reg[2] <= NRM_W'(prod_reg[4]) - NRM_W'(prod_reg[5]);
            dir3_reg   <= dir2_reg;
        end
    end

    // Stage 4: per-axis dot and square terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nd_reg[i] <= ND_W'(nrm_reg[i]) * ND_W'(dir3_reg[i]);
                nn_reg[i] <= $unsigned(NN_W'(nrm_reg[i]) * NN_W'(nrm_reg[i]));
                dd_reg[i] <= $unsigned(DD_W'(dir3_reg[i]) * DD_W'(dir3_reg[i]));
            end
        end
    end

    // Stage 5: sums over axes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg <= DOT_W'(nd_reg[0]) + DOT_W'(nd_reg[1]) + DOT_W'(nd_reg[2]);
            n2_reg  <= nn_reg[0] + nn_reg[1] + nn_reg[2];
            d2_reg  <= dd_reg[0] + dd_reg[1] + dd_reg[2];
        end
    end

    // Stage 6: facing test, gain times dot, base halves
    assign lit_now = ~dot_reg[DOT_W-1] & (dot_reg != '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gd_reg <= lit_now ? GD_W'(diffuse_reg) * GD_W'(dot_reg[DOTMAG_W-1:0])
                              : '0;
            bl_reg <= BP_W'(n2_reg[HALF_NN_W-1:0]) * BP_W'(d2_reg);
            bh_reg <= BP_W'(n2_reg[NN_W-1:HALF_NN_W]) * BP_W'(d2_reg);
        end
    end

    // Stage 7: merge base, square partials of gain times dot
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base7_reg <= (BASE_W'(bh_reg) << HALF_NN_W) + BASE_W'(bl_reg);
            ll_reg    <= (2*GD_LO_W)'(gd_reg[GD_LO_W-1:0])
                       * (2*GD_LO_W)'(gd_reg[GD_LO_W-1:0]);
            lh_reg    <= (2*GD_LO_W)'(gd_reg[GD_LO_W-1:0])
                       * (2*GD_LO_W)'(gd_reg[GD_W-1:GD_LO_W]);
            hh_reg    <= (2*GD_LO_W)'(gd_reg[GD_W-1:GD_LO_W])
                       * (2*GD_LO_W)'(gd_reg[GD_W-1:GD_LO_W]);
        end
    end

    // Stage 8: right-hand side, seed the search
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srch_r_reg[0]    <= (RES_W'(hh_reg) << (2*GD_LO_W))
                              + (RES_W'(lh_reg) << (GD_LO_W+1))
                              + RES_W'(ll_reg);
            srch_kb_reg[0]   <= '0;
            srch_k_reg[0]    <= '0;
            srch_base_reg[0] <= base7_reg;
        end
    end

    // Carry the facing flag down the pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lit_pipe_reg <= {lit_pipe_reg[15:6], lit_now};
        end
    end

    // Stages 9..16: one level bit per stage, from the top bit down
    for (genvar g = 0; g < SEARCH_STEPS; g++)
    begin : g_search
        localparam int J = SEARCH_STEPS - 1 - g;

        logic [RES_W-1:0] delta;
        logic             take;

        assign delta = (RES_W'(srch_kb_reg[g]) << (J+1))
                     + (RES_W'(srch_base_reg[g]) << (2*J));
        assign take  = delta <= srch_r_reg[g];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srch_r_reg[g+1]    <= take ? srch_r_reg[g] - delta : srch_r_reg[g];
                srch_kb_reg[g+1]   <= take ? srch_kb_reg[g]
                                           + (KB_W'(srch_base_reg[g]) << J)
                                         : srch_kb_reg[g];
                srch_k_reg[g+1]    <= srch_k_reg[g] | (LEVEL_W'(take) << J);
                srch_base_reg[g+1] <= srch_base_reg[g];
            end
        end
    end

    // Stage 17: add ambient and clamp
    assign k_use   = lit_pipe_reg[16] ? srch_k_reg[SEARCH_STEPS] : '0;
    assign lvl_sum = SUMLVL_W'(ambient_reg) + SUMLVL_W'(k_use);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray_reg <= lvl_sum[SUMLVL_W-1] ? LEVEL_MAX : lvl_sum[LEVEL_W-1:0];
            lit_reg  <= lit_pipe_reg[16];
        end
    end

    assign out_valid  = vld_reg[PIPE_DEPTH-1];
    assign gray_level = gray_reg;
    assign lit_face   = lit_reg;

    // Checks
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_floor_ambient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gray_level >= ambient_reg)
        else $error("gray level below ambient");

    a_unlit_ambient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !lit_face |-> gray_level == ambient_reg)
        else $error("unlit face not at ambient level");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Flat triangle shading testbench
// Drives triangles through the valid/ready input channel under random gaps,
// stalls the output channel at random, and checks gray level and facing flag
// against an exact integer prediction of the Lambert term. Light, ambient and
// gain are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class shade_scoreboard;
    logic [7:0] gray_q[$];
    logic       lit_q[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    // note the expected shading of an accepted triangle
    function void note_triangle(logic [7:0] g, logic l);
        gray_q = {gray_q, g};
        lit_q = {lit_q, l};
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_shade(logic [7:0] g, logic l);
        logic [7:0] eg;
        logic       el;
        if (gray_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result: gray %0d lit %0d", g, l);
            return;
        end
        eg = gray_q.pop_front();
        el = lit_q.pop_front();
        if (eg !== g || el !== l) begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected gray %0d lit %0d, got gray %0d lit %0d",
                         eg, el, g, l);
        end
    endfunction

    function int pending();
        return gray_q.size();
    endfunction
endclass

module tb_top;
    import fts_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_LIGHT_X;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [COORD_W-1:0] vtx [9];
    logic out_valid;
    logic out_ready = 0;
    logic [LEVEL_W-1:0] gray_level;
    logic lit_face;

    shade_scoreboard sb = new();

    // shadow copy of the configuration
    logic signed [15:0] light_pos [3];
    logic [7:0] ambient_lvl, diffuse_lvl;
    longint cycles = 0;
    bit stim_done = 0;

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < 9; i++)
            vtx[i] = '0;
    end

    flat_triangle_shading DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .ax(vtx[0]), .ay(vtx[1]), .az(vtx[2]),
        .bx(vtx[3]), .by_coord(vtx[4]), .bz(vtx[5]),
        .cx(vtx[6]), .cy(vtx[7]), .cz(vtx[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .gray_level(gray_level), .lit_face(lit_face)
    );

    // predict gray level and facing flag with exact wide arithmetic
    task automatic shade_triangle(output logic [7:0] g, output logic l);
        logic signed [127:0] e1[3], e2[3], n[3], d[3], dot, n2, d2;
        logic [255:0] base, rhs;
        logic [8:0] k, t;
        logic [9:0] sum;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 128'(vtx[3+i]) - 128'(vtx[i]);
            e2[i] = 128'(vtx[6+i]) - 128'(vtx[i]);
            d[i] = 128'(light_pos[i]) * 3 - 128'(vtx[i]) - 128'(vtx[3+i])
                   - 128'(vtx[6+i]);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dot = 0; n2 = 0; d2 = 0;
        for (int i = 0; i < 3; i++) begin
            dot += n[i] * d[i];
            n2 += n[i] * n[i];
            d2 += d[i] * d[i];
        end
        l = dot > 0;
        k = 0;
        if (l) begin
            base = 256'(n2) * 256'(d2);
            rhs = 256'(diffuse_lvl) * 256'(diffuse_lvl) * 256'(dot) * 256'(dot);
            for (int b = 7; b >= 0; b--) begin
                t = k | (9'd1 << b);
                if (256'(t) * 256'(t) * base <= rhs)
                    k = t;
            end
        end
        sum = 10'(ambient_lvl) + 10'(k);
        g = (sum > 255) ? 8'd255 : sum[7:0];
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_LIGHT_X: light_pos[0] = val;
            REG_LIGHT_Y: light_pos[1] = val;
            REG_LIGHT_Z: light_pos[2] = val;
            REG_AMBIENT: ambient_lvl = val[7:0];
            REG_DIFFUSE: diffuse_lvl = val[7:0];
            default: ;
        endcase
    endtask

    // drop valid, wait for an empty pipeline, plus its latency
    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                              logic [7:0] amb, logic [7:0] gain);
        drain();
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
        write_reg(REG_AMBIENT, {8'(0), amb});
        write_reg(REG_DIFFUSE, {8'(0), gain});
    endtask

    // present one triangle and hold it until the transfer
    task automatic send_triangle(logic signed [15:0] v[9]);
        logic [7:0] g;
        logic l;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        for (int i = 0; i < 9; i++)
            vtx[i] <= v[i];
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shade_triangle(g, l);
        sb.note_triangle(g, l);
        @(negedge clk);
    endtask

    task automatic rand_triangle(int mode);
        logic signed [15:0] v[9];
        int span;
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(64, 4000);
        for (int i = 0; i < 9; i++)
            v[i] = (span == 32767) ? 16'($urandom) :
                   16'($urandom_range(0, 2 * span) - span);
        // occasionally make it degenerate or collinear
        if (mode == 1) begin
            for (int i = 0; i < 3; i++)
                v[3+i] = v[i];
        end else if (mode == 2) begin
            for (int i = 0; i < 3; i++)
                v[6+i] = 16'(2 * int'(v[3+i]) - int'(v[i]));
        end
        send_triangle(v);
    endtask

    task automatic directed();
        logic signed [15:0] v[9];
        logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
        // extremes of every field
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 9; i++)
                v[i] = ext[(i + j) % 4];
            send_triangle(v);
        end
        for (int i = 0; i < 9; i++)
            v[i] = ext[i % 2];
        send_triangle(v);
        // facing toward and away from the light
        v = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
        send_triangle(v);
        v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
        send_triangle(v);
        // degenerate: all vertices equal
        v = '{16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100,
              16'sd100, 16'sd100, 16'sd100};
        send_triangle(v);
        // light at centroid
        v = '{16'sd5120, 16'sd5120, 16'sd4864, 16'sd5376, 16'sd5120, 16'sd5120,
              16'sd4864, 16'sd5120, 16'sd5376};
        send_triangle(v);
        for (int i = 0; i < 6; i++)
            rand_triangle(i % 3);
    endtask

    // stimulus
    initial
    begin
        light_pos = '{16'sd5120, 16'sd5120, 16'sd5120};
        ambient_lvl = 30;
        diffuse_lvl = 200;
        repeat (2) @(negedge clk);
        rst_n = 1;
        directed();
        // saturating: full ambient and gain
        set_config(16'h7FFF, 16'h8000, 16'h0000, 8'd255, 8'd255);
        directed();
        set_config(16'h8000, 16'h7FFF, 16'hFFFF, 8'd0, 8'd0);
        directed();
        set_config(16'h0000, 16'h0000, 16'h0100, 8'd0, 8'd255);
        directed();
        for (int p = 0; p < 8; p++) begin
            set_config(16'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom), 8'($urandom));
            for (int n = 0; n < 90; n++)
                rand_triangle(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            // hold off until all results are back
            drain();
        end
        drain();
        stim_done = 1;
    end

    // receiver with random stalls
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_shade(gray_level, lit_face);
        end
    end

    // end of run and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (stim_done) begin
            if (sb.pending() == 0 && sb.errors == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end else if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end
endmodule
